// ----- sv/irfpe_pkg.sv -----
package irfpe_pkg;

  localparam int FRAME_REPEATS = 2;
  localparam int COPY_LEN      = 132;
  localparam int OFF_W         = $clog2(COPY_LEN);
  localparam int COPY_W        = (FRAME_REPEATS > 1) ? $clog2(FRAME_REPEATS) : 1;
  localparam int DUR_W         = 16;
  localparam int CFG_IDX_W     = 3;

  // Byte 0 is element [0].
  typedef logic [7:0][7:0] frame_t;

  localparam frame_t FRAME_RESET = {8'h0b, 8'h00, 8'h30, 8'h00, 8'h00, 8'h30, 8'h14, 8'h01};
  localparam frame_t FRAME_OFF   = {8'h15, 8'h00, 8'hc0, 8'h00, 8'h00, 8'h30, 8'h14, 8'h01};

  localparam logic [7:0] SWING_MASK = 8'hc0;
  localparam logic [7:0] SWING_ADJ  = 8'hb4;
  localparam logic [7:0] NIBBLE_MUL = 8'h0f;
  localparam logic [7:0] TEMP_BIAS  = 8'd3;

  localparam logic [DUR_W-1:0] HDR_MARK_RST  = 16'd8000;
  localparam logic [DUR_W-1:0] HDR_SPACE_RST = 16'd4000;
  localparam logic [DUR_W-1:0] LONG_RST      = 16'd1618;
  localparam logic [DUR_W-1:0] SHORT_RST     = 16'd545;
  localparam logic [DUR_W-1:0] GAP_SPACE_RST = 16'd31000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_MARK  = 3'd0,
    CFG_HDR_SPACE = 3'd1,
    CFG_LONG      = 3'd2,
    CFG_SHORT     = 3'd3,
    CFG_GAP_SPACE = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_PULL = 1'b1
  } req_t;

  typedef struct packed {
    logic       req_type;
    logic       power;
    logic [3:0] mode;
    logic [3:0] fan;
    logic [6:0] temperature;
    logic       swing;
  } in_word_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration_us;
    logic             is_mark;
    logic             last;
  } res_t;

  typedef struct packed {
    logic run_active;
  } frm_stat_t;

  // Check byte over bytes 0..6, kept to 8 bits.
  function automatic logic [7:0] check_byte(frame_t f);
    logic [7:0] sum;
    logic [7:0] t_term;
    logic [7:0] f_term;
    logic [7:0] s_term;
    sum    = f[0] + f[1] + f[2] + f[3] + f[4] + f[5] + f[6];
    t_term = NIBBLE_MUL * (TEMP_BIAS + {4'b0, f[2][7:4]});
    f_term = NIBBLE_MUL * {4'b0, f[1][7:4]};
    s_term = ((f[6] & SWING_MASK) != 8'h00) ? SWING_ADJ : 8'h00;
    return sum - t_term - f_term - s_term;
  endfunction

endpackage

// ----- sv/irfpe_in_if.sv -----
interface irfpe_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       power;
  logic [3:0] mode;
  logic [3:0] fan;
  logic [6:0] temperature;
  logic       swing;

  modport source (output valid, req_type, power, mode, fan, temperature, swing, input ready);
  modport sink   (input valid, req_type, power, mode, fan, temperature, swing, output ready);
endinterface

// ----- sv/irfpe_out_if.sv -----
interface irfpe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duration_us;
  logic        is_mark;
  logic        last;

  modport source (output valid, duration_us, is_mark, last, input ready);
  modport sink   (input valid, duration_us, is_mark, last, output ready);
endinterface

// ----- sv/irfpe_frame.sv -----
module irfpe_frame
  import irfpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DUR_W-1:0]     cfg_data,
  input  logic                 acc,
  input  in_word_t             word,
  output logic                 res_vld,
  output res_t                 res,
  output frm_stat_t            stat
);

  logic [DUR_W-1:0]  hdr_mark_r, hdr_space_r, long_r, short_r, gap_space_r;
  frame_t            frame_r;
  frame_t            frame_nxt;
  frame_t            frame_on;
  logic [OFF_W-1:0]  off_r;
  logic [COPY_W-1:0] copy_r;
  logic              run_r;

  logic [OFF_W-1:0]  off_m2;
  logic [5:0]        bit_idx;
  logic              bit_val;
  logic              mark;
  logic              last_copy;
  logic              off_end;
  logic              is_pull;

  // Power-on frame: bytes 0, 3, 4, 5 kept.
  always_comb begin
    frame_on    = frame_r;
    frame_on[1] = {word.fan + 4'd1, word.mode};
    frame_on[2] = {word.temperature, 1'b0};
    frame_on[6] = word.swing ? (frame_r[6] | SWING_MASK) : (frame_r[6] & ~SWING_MASK);
    frame_on[7] = check_byte(frame_on);
    frame_nxt   = word.power ? frame_on : FRAME_OFF;
  end

  assign off_m2    = off_r - OFF_W'(2);
  assign bit_idx   = off_m2[6:1];
  assign bit_val   = frame_r[bit_idx[5:3]][bit_idx[2:0]];
  assign mark      = ~off_r[0];
  assign last_copy = (copy_r == COPY_W'(FRAME_REPEATS - 1));
  assign off_end   = (off_r == OFF_W'(COPY_LEN - 1));
  assign is_pull   = (word.req_type == REQ_PULL);

  always_comb begin
    if (off_r < OFF_W'(2)) begin
      res.duration_us = mark ? hdr_mark_r : hdr_space_r;
    end else if (off_r < OFF_W'(COPY_LEN - 2)) begin
      res.duration_us = (mark ^ ~bit_val) ? long_r : short_r;
    end else if (!last_copy) begin
      res.duration_us = mark ? long_r : gap_space_r;
    end else begin
      res.duration_us = long_r;
    end
    res.is_mark = mark;
    res.last    = last_copy & off_end;
  end

  assign res_vld         = acc & is_pull & run_r;
  assign stat.run_active = run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mark_r  <= HDR_MARK_RST;
      hdr_space_r <= HDR_SPACE_RST;
      long_r      <= LONG_RST;
      short_r     <= SHORT_RST;
      gap_space_r <= GAP_SPACE_RST;
      frame_r     <= FRAME_RESET;
      off_r       <= '0;
      copy_r      <= '0;
      run_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_HDR_MARK:  hdr_mark_r  <= cfg_data;
          CFG_HDR_SPACE: hdr_space_r <= cfg_data;
          CFG_LONG:      long_r      <= cfg_data;
          CFG_SHORT:     short_r     <= cfg_data;
          CFG_GAP_SPACE: gap_space_r <= cfg_data;
          default: ;
        endcase
      end
      if (acc && !is_pull) begin
        frame_r <= frame_nxt;
        off_r   <= '0;
        copy_r  <= '0;
        run_r   <= 1'b1;
      end else if (res_vld) begin
        if (off_end) begin
          off_r <= '0;
          if (last_copy) begin
            copy_r <= '0;
            run_r  <= 1'b0;
          end else begin
            copy_r <= copy_r + COPY_W'(1);
          end
        end else begin
          off_r <= off_r + OFF_W'(1);
        end
      end
    end
  end

endmodule

// ----- sv/irfpe_outbuf.sv -----
module irfpe_outbuf
  import irfpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_vld,
  input  res_t               res,
  output logic               in_ready,
  irfpe_out_if.source        out_ch
);

  res_t out_r, skid_r;
  logic out_vld_r, skid_vld_r;
  logic out_free;

  assign out_free = ~out_vld_r | out_ch.ready;
  assign in_ready = ~skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r | res_vld;
      skid_vld_r <= 1'b0;
    end else if (res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.duration_us = out_r.duration_us;
  assign out_ch.is_mark     = out_r.is_mark;
  assign out_ch.last        = out_r.last;

endmodule

// ----- sv/ir_aircon_frame_pulse_encoder_unit.sv -----
// A pull word accepted during a run has its duration word registered in the output buffer, which drives out_ch.
// Throughput: one input word per cycle while the skid entry is empty; a load word gives no result.
// The rate is set by the single frame/counter stage feeding a two-entry output buffer.
// Reset (rst_n low, synchronous): timing registers and frame return to defaults,
// run goes idle, output buffer empties.
module ir_aircon_frame_pulse_encoder_unit
  import irfpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DUR_W-1:0]     cfg_data,
  irfpe_in_if.sink             in_ch,
  irfpe_out_if.source          out_ch
);

  in_word_t  word;
  logic      acc;
  logic      in_ready;
  logic      res_vld;
  res_t      res;
  frm_stat_t stat;

  // Input word is consumed straight into the frame/counter state.
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid & in_ready;

  assign word.req_type    = in_ch.req_type;
  assign word.power       = in_ch.power;
  assign word.mode        = in_ch.mode;
  assign word.fan         = in_ch.fan;
  assign word.temperature = in_ch.temperature;
  assign word.swing       = in_ch.swing;

  // Frame store, run counters, duration select.
  irfpe_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .acc      (acc),
    .word     (word),
    .res_vld  (res_vld),
    .res      (res),
    .stat     (stat)
  );

  // Output register plus skid entry; ready drops only when both are full.
  irfpe_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_vld  (res_vld),
    .res      (res),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_pull_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.req_type == REQ_PULL && stat.run_active) |=> out_ch.valid)
    else $error("pull during run produced no output word");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.last) |=> !stat.run_active)
    else $error("run still active after last duration");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty output register");

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.req_type == REQ_LOAD) |=> stat.run_active)
    else $error("load did not start a run");
`endif

endmodule

// ----- tb/sv/ir_aircon_frame_pulse_encoder_unit_tb.sv -----
`timescale 1ns / 100ps

module ir_aircon_frame_pulse_encoder_unit_tb;
  import irfpe_pkg::*;

  // run shape
  localparam int RUN_PULSES   = COPY_LEN * FRAME_REPEATS;
  localparam int BITS_END     = COPY_LEN - 2;   // first offset past the 64 bit pairs
  localparam int IN_W         = $bits(in_word_t);

  // stimulus / timing knobs
  localparam int RANDOM_WORDS = 740;
  localparam int HOLD_CYCLES  = 48;             // long receiver hold-off
  localparam int IDLE_TAIL    = 4;              // margin after the last owed duration comes out
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 40;

  // frame images, byte 0 in element [0]
  localparam frame_t BOOT_FRAME = {8'h0b, 8'h00, 8'h30, 8'h00, 8'h00, 8'h30, 8'h14, 8'h01};
  localparam frame_t OFF_FRAME  = {8'h15, 8'h00, 8'hc0, 8'h00, 8'h00, 8'h30, 8'h14, 8'h01};

  // check byte terms
  localparam logic [7:0] SWING_BITS    = 8'hc0;
  localparam int         SWING_CORR    = 180;
  localparam int         CHK_STEP      = 15;
  localparam int         CHK_TEMP_BIAS = 3;

  // timing after reset
  localparam logic [DUR_W-1:0] BOOT_HDR_MARK  = 16'd8000;
  localparam logic [DUR_W-1:0] BOOT_HDR_SPACE = 16'd4000;
  localparam logic [DUR_W-1:0] BOOT_LONG      = 16'd1618;
  localparam logic [DUR_W-1:0] BOOT_SHORT     = 16'd545;
  localparam logic [DUR_W-1:0] BOOT_GAP_SPACE = 16'd31000;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DUR_W-1:0]     cfg_data;

  irfpe_in_if  in_ch ();
  irfpe_out_if out_ch ();

  ir_aircon_frame_pulse_encoder_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Encoder model: frame, position in the run, timing registers
  // ---------------------------------------------------------------------------
  frame_t           frame_now;
  int unsigned      pulse_pos;
  bit               run_on;
  logic [DUR_W-1:0] hdr_mark_t;
  logic [DUR_W-1:0] hdr_space_t;
  logic [DUR_W-1:0] long_t;
  logic [DUR_W-1:0] short_t;
  logic [DUR_W-1:0] gap_space_t;

  // durations still owed by the block, oldest first
  res_t expected_pulses [$];

  // bookkeeping
  int mismatches         = 0;
  int words_in           = 0;
  int pulses_checked     = 0;
  int runs_done          = 0;
  int input_stall_cycles = 0;
  int timing_writes      = 0;
  int cycle_count        = 0;
  int spare_pick         = 0;

  // idling controls, set by the tests
  bit sender_gaps  = 1'b0;
  bit sink_stalls  = 1'b0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;
  int sink_quiet   = 0;
  int send_quiet   = 0;

  // checksum over bytes 0..6, low 8 bits kept
  function automatic logic [7:0] frame_sum_byte(frame_t f);
    int unsigned total;
    int unsigned temp_part;
    int unsigned fan_part;
    int unsigned swing_part;
    total = 0;
    for (int i = 0; i < 7; i++) total += f[i];
    temp_part  = CHK_STEP * (CHK_TEMP_BIAS + (f[2] >> 1) / 8);
    fan_part   = CHK_STEP * f[1][7:4];
    swing_part = ((f[6] & SWING_BITS) != 8'h00) ? SWING_CORR : 0;
    return 8'(total - temp_part - fan_part - swing_part);
  endfunction

  // duration at a run position: header, 64 bit pairs LSB first, gap or trailer
  function automatic logic [DUR_W-1:0] pulse_duration(int unsigned p);
    int unsigned copy_no;
    int unsigned off;
    int unsigned bit_no;
    logic        mark;
    logic        one;
    copy_no = p / COPY_LEN;
    off     = p % COPY_LEN;
    mark    = (off % 2 == 0);
    if (off < 2) return mark ? hdr_mark_t : hdr_space_t;
    if (off < BITS_END) begin
      bit_no = (off - 2) / 2;
      one    = frame_now[bit_no / 8][bit_no % 8];
      if (mark) return one ? long_t : short_t;
      return one ? short_t : long_t;
    end
    if (copy_no + 1 < FRAME_REPEATS) return mark ? long_t : gap_space_t;
    return long_t;
  endfunction

  // one accepted word: a load rebuilds the frame and restarts, a pull owes a duration
  function automatic void apply_word(in_word_t w);
    logic [3:0] fan_code;
    res_t       r;
    if (w.req_type == REQ_LOAD) begin
      if (w.power) begin
        fan_code     = w.fan + 4'd1;          // fan 15 wraps to 0
        frame_now[1] = {fan_code, w.mode};
        frame_now[2] = {w.temperature, 1'b0};
        frame_now[6] = w.swing ? (frame_now[6] | SWING_BITS) : (frame_now[6] & ~SWING_BITS);
        frame_now[7] = frame_sum_byte(frame_now);
      end else begin
        frame_now = OFF_FRAME;
      end
      pulse_pos = 0;
      run_on    = 1'b1;
    end else if (run_on) begin
      r.duration_us = pulse_duration(pulse_pos);
      r.is_mark     = (pulse_pos % 2 == 0);
      r.last        = (pulse_pos + 1 == RUN_PULSES);
      expected_pulses.push_back(r);
      pulse_pos++;
      if (pulse_pos >= RUN_PULSES) begin
        pulse_pos = 0;
        run_on    = 1'b0;
      end
    end
    // pull while idle: nothing
  endfunction

  function automatic void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] d);
    case (idx)
      CFG_HDR_MARK:  hdr_mark_t  = d;
      CFG_HDR_SPACE: hdr_space_t = d;
      CFG_LONG:      long_t      = d;
      CFG_SHORT:     short_t     = d;
      CFG_GAP_SPACE: gap_space_t = d;
      default: ;                               // spare index: dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic in_word_t load_word(logic pwr, logic [3:0] mode, logic [3:0] fan,
                                         logic [6:0] temp, logic swing);
    in_word_t w;
    w.req_type    = REQ_LOAD;
    w.power       = pwr;
    w.mode        = mode;
    w.fan         = fan;
    w.temperature = temp;
    w.swing       = swing;
    return w;
  endfunction

  // random fields, power on three times out of four
  function automatic in_word_t random_load();
    in_word_t w;
    w          = IN_W'($urandom);
    w.req_type = REQ_LOAD;
    w.power    = ($urandom_range(0, 3) != 0);
    return w;
  endfunction

  // pull with junk in the unused fields
  function automatic in_word_t pull_word();
    in_word_t w;
    w          = IN_W'($urandom);
    w.req_type = REQ_PULL;
    return w;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return DUR_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------
  // Offer one word, hold it until accepted. valid stays high into the next word
  // unless a gap is taken.
  task automatic send_word(in_word_t w);
    if (send_quiet > 0) begin
      send_quiet--;
    end else if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else if ($urandom_range(0, 29) == 0) begin
      send_quiet = $urandom_range(10, 60);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= w.req_type;
    in_ch.power       <= w.power;
    in_ch.mode        <= w.mode;
    in_ch.fan         <= w.fan;
    in_ch.temperature <= w.temperature;
    in_ch.swing       <= w.swing;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    apply_word(w);
    words_in++;
  endtask

  // drop valid, let every owed duration come out, then a few more edges
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; lowered once by the caller
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    note_reg_write(idx, d);
  endtask

  // all five timing registers, then one spare index that must be ignored
  task automatic program_timing(logic [DUR_W-1:0] hm, logic [DUR_W-1:0] hs,
                                logic [DUR_W-1:0] lg, logic [DUR_W-1:0] sh,
                                logic [DUR_W-1:0] gp);
    logic [CFG_IDX_W-1:0] spare;
    case (spare_pick % 3)
      0:       spare = CFG_SPARE_5;
      1:       spare = CFG_SPARE_6;
      default: spare = CFG_SPARE_7;
    endcase
    spare_pick++;
    write_reg(CFG_HDR_MARK, hm);
    write_reg(CFG_HDR_SPACE, hs);
    write_reg(CFG_LONG, lg);
    write_reg(CFG_SHORT, sh);
    write_reg(CFG_GAP_SPACE, gp);
    write_reg(spare, DUR_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    timing_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, quiet stretches, one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (sink_quiet > 0) begin
      sink_quiet--;
      out_ch.ready <= 1'b1;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;   // this edge counts as the first
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 39) == 0) sink_quiet = $urandom_range(10, 60);
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (in_ch.valid === 1'b1 && in_ch.ready !== 1'b1) input_stall_cycles++;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected duration word, expected none actual %0d mark %0b last %0b",
                   $time, out_ch.duration_us, out_ch.is_mark, out_ch.last);
      end else begin
        want = expected_pulses.pop_front();
        if (out_ch.duration_us !== want.duration_us)
          report_field("duration_us", want.duration_us, out_ch.duration_us);
        if (out_ch.is_mark !== want.is_mark)
          report_field("is_mark", want.is_mark, out_ch.is_mark);
        if (out_ch.last !== want.last)
          report_field("last", want.last, out_ch.last);
        pulses_checked++;
        if (want.last) runs_done++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // pulls before any load: no run, so nothing may come out
  task automatic test_idle_pulls();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (4) send_word(pull_word());
    wait_idle();
  endtask

  // field extremes, fan wrap, power off, swing set and cleared, loads mid-run
  task automatic test_load_cases();
    send_word(load_word(1'b1, 4'hf, 4'hf, 7'h7f, 1'b1));
    repeat (3) send_word(pull_word());
    send_word(load_word(1'b1, 4'h0, 4'h0, 7'h00, 1'b0));   // restart mid-run
    repeat (2) send_word(pull_word());
    send_word(load_word(1'b0, 4'h9, 4'h3, 7'h55, 1'b1));   // off frame, fields unused
    repeat (2) send_word(pull_word());
    send_word(load_word(1'b1, 4'ha, 4'he, 7'h2a, 1'b1));
    send_word(load_word(1'b1, 4'h5, 4'h1, 7'h15, 1'b0));   // back-to-back loads
    repeat (3) send_word(pull_word());
    send_word(load_word(1'b1, 4'h3, 4'h7, 7'h40, 1'b0));
    repeat (2) send_word(pull_word());
    wait_idle();
  endtask

  // whole runs under reset, all-zero, all-one and random timing; trailing pulls
  // fall past the end of the run and must give nothing
  task automatic test_timing_settings();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: ;                                     // reset timing
        1: program_timing('0, '0, '0, '0, '0);
        2: program_timing('1, '1, '1, '1, '1);
        default: program_timing(DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom),
                                DUR_W'($urandom), DUR_W'($urandom));
      endcase
      if (phase == 2) send_word(load_word(1'b0, 4'h0, 4'h0, 7'h00, 1'b0));
      else            send_word(load_word(1'b1, 4'($urandom), 4'($urandom), 7'($urandom),
                                          phase[0]));
      repeat (RUN_PULSES + 2) send_word(pull_word());
      wait_idle();
    end
  endtask

  // receiver holds off while pulls keep coming: buffer fills, input stalls
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    send_word(random_load());
    hold_request = 1'b1;
    repeat (30) send_word(pull_word());
    wait_idle();
    sender_gaps = 1'b1;
  endtask

  // Mostly load + pulls: full runs, runs cut short by the next load, a few
  // pulls past the end, stray words, and new timing between runs. The tail
  // of the test runs with no idling on either side.
  task automatic test_random_traffic();
    int unsigned done_words;
    int unsigned n;
    int unsigned pick;
    in_word_t    w;
    done_words  = 0;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    while (done_words < RANDOM_WORDS) begin
      if (done_words > RANDOM_WORDS * 85 / 100) begin
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        w = IN_W'($urandom);                     // stray word of either kind
        if (w.req_type == REQ_LOAD || run_on) done_words++;
        send_word(w);
      end else if (pick < 10 && !run_on && done_words < RANDOM_WORDS * 80 / 100) begin
        wait_idle();
        program_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                       pick_duration());
      end else begin
        send_word(random_load());
        done_words++;
        if ($urandom_range(0, 9) < 6) n = RUN_PULSES + $urandom_range(0, 2);
        else                          n = $urandom_range(1, RUN_PULSES - 1);
        repeat (n) begin
          if (run_on) done_words++;
          send_word(pull_word());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout, %0d durations still owed", $time, expected_pulses.size());
    $display("ir_aircon_frame_pulse_encoder_unit_tb NOT OK");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_HDR_MARK;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_PULL;
    in_ch.power       <= 1'b0;
    in_ch.mode        <= '0;
    in_ch.fan         <= '0;
    in_ch.temperature <= '0;
    in_ch.swing       <= 1'b0;
    out_ch.ready      <= 1'b0;

    // model state after reset
    frame_now   = BOOT_FRAME;
    pulse_pos   = 0;
    run_on      = 1'b0;
    hdr_mark_t  = BOOT_HDR_MARK;
    hdr_space_t = BOOT_HDR_SPACE;
    long_t      = BOOT_LONG;
    short_t     = BOOT_SHORT;
    gap_space_t = BOOT_GAP_SPACE;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_pulls();
    test_load_cases();
    test_timing_settings();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();

    $display("covered %0d input words, %0d duration words checked, %0d complete runs",
             words_in, pulses_checked, runs_done);
    $display("timing reprogrammed %0d times, input held off %0d cycles by a full output",
             timing_writes, input_stall_cycles);
    if (mismatches == 0) begin
      $display("ir_aircon_frame_pulse_encoder_unit_tb OK");
    end else begin
      $display("ir_aircon_frame_pulse_encoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
